// ----- rtl/crc64id_pkg.sv -----
// Shared types, constants and functions for the CRC-64 device id encoder.
package crc64id_pkg;

  localparam int unsigned CRC_W     = 64;
  localparam int unsigned OS_CODE_W = 5;
  localparam int unsigned CODE_W    = 6;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ID_CHARS  = 10;
  localparam int unsigned CHAR_IDX_W = 4;
  localparam int unsigned FIELD_STRIDE = 7;

  localparam logic [CRC_W-1:0]     CRC_POLY      = 64'hC96C5795D7870F42;
  localparam logic [OS_CODE_W-1:0] OS_CODE_RESET = 5'd2;
  localparam logic [CHAR_IDX_W-1:0] LAST_CHAR_IDX = 4'(ID_CHARS - 1);

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_X = 8'h58;

  localparam logic [CHAR_W-1:0] LOWER_BASE = 8'd26;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd52;

  // Finished CRC handed from front end to back end.
  typedef struct packed {
    logic             valid;
    logic [CRC_W-1:0] crc;
  } crc_entry_t;

  // Reflected CRC-64, one byte folded in.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [7:0]       data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {56'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  // 6-bit code to id alphabet.
  function automatic logic [CHAR_W-1:0] code_to_ascii(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] wide;
    logic [CHAR_W-1:0] ch;
    wide = {2'b00, code};
    if (code inside {[6'd0:6'd25]})       ch = ASCII_UPPER_A + wide;
    else if (code inside {[6'd26:6'd51]}) ch = ASCII_LOWER_A + (wide - LOWER_BASE);
    else if (code inside {[6'd52:6'd61]}) ch = ASCII_ZERO + (wide - DIGIT_BASE);
    else if (code == 6'd62)               ch = ASCII_LOWER_X;
    else                                  ch = ASCII_UPPER_X;
    return ch;
  endfunction

endpackage

// ----- rtl/crc64id_if.sv -----
// Valid/ready channel interfaces for message bytes and id characters.
interface crc64id_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source(output valid, data_byte, byte_present, message_end, input ready);
  modport sink(input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface crc64id_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  id_char;
  logic        char_last;
  logic [63:0] crc_value;

  modport source(output valid, id_char, char_last, crc_value, input ready);
  modport sink(input valid, id_char, char_last, crc_value, output ready);
endinterface

// ----- rtl/crc64_device_id_encoder.sv -----
// Top level of the CRC-64 device id encoder.
//
// msg_in carries one message byte per transfer (data_byte, byte_present) plus
// message_end. Bytes fold into a reflected CRC-64 (poly 0xC96C5795D7870F42,
// zero init, no final xor) at one transfer per cycle while msg_in.ready is
// high; an end-only transfer closes the message without a byte, so empty
// messages give CRC 0. At message end the finished CRC goes into a
// QUEUE_DEPTH-entry queue and the running CRC clears. The back end turns
// each queued CRC into ten ASCII id characters on id_out, one per cycle
// unless id_out stalls, each carrying crc_value; char_last marks the tenth.
// Throughput: one byte per cycle in while the queue is not full; after the
// tenth character the back end goes idle to pop the next queued CRC, so the
// character loop sets the sustained message rate. When id_out stalls the
// output register holds; beyond the id being expanded the queue absorbs
// QUEUE_DEPTH ended messages before msg_in.ready drops.
// os_code (reset 2) is written through os_code_we/os_code_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// rst (synchronous) clears the CRC, empties the queue and drops id_out.valid.
module crc64_device_id_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  crc64id_in_if.sink                        msg_in,
  crc64id_out_if.source                     id_out,
  input  logic                              os_code_we,
  input  logic [crc64id_pkg::OS_CODE_W-1:0] os_code_wdata
);

  logic [crc64id_pkg::OS_CODE_W-1:0] os_code;
  crc64id_pkg::crc_entry_t           push;
  crc64id_pkg::crc_entry_t           head;
  logic                              queue_full;
  logic                              pop;

  // platform code register
  always_ff @(posedge clk) begin
    if (rst) begin
      os_code <= crc64id_pkg::OS_CODE_RESET;
    end else if (os_code_we) begin
      os_code <= os_code_wdata;
    end
  end

  crc64id_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg_in     (msg_in),
    .queue_full (queue_full),
    .push       (push)
  );

  crc64id_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (queue_full)
  );

  crc64id_back u_back (
    .clk     (clk),
    .rst     (rst),
    .os_code (os_code),
    .head    (head),
    .pop     (pop),
    .id_out  (id_out)
  );

endmodule

// ----- rtl/crc64id_front.sv -----
// Front end: takes message bytes, keeps the running CRC, queues finished CRCs.
module crc64id_front (
  input  logic                    clk,
  input  logic                    rst,
  crc64id_in_if.sink              msg_in,
  input  logic                    queue_full,
  output crc64id_pkg::crc_entry_t push
);

  logic [crc64id_pkg::CRC_W-1:0] crc;
  logic [crc64id_pkg::CRC_W-1:0] crc_next;
  logic                          accept;

  assign msg_in.ready = !queue_full;
  assign accept       = msg_in.valid && msg_in.ready;

  always_comb begin
    if (msg_in.byte_present) crc_next = crc64id_pkg::crc_byte(crc, msg_in.data_byte);
    else                     crc_next = crc;
  end

  assign push.valid = accept && msg_in.message_end;
  assign push.crc   = crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
    end else if (accept) begin
      if (msg_in.message_end) crc <= '0;
      else                    crc <= crc_next;
    end
  end

  a_crc_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && msg_in.message_end) |=> (crc == '0))
    else $error("running CRC not cleared after message end");

endmodule

// ----- rtl/crc64id_queue.sv -----
// Short FIFO of finished CRC values between front and back end.
module crc64id_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  crc64id_pkg::crc_entry_t push,
  input  logic                    pop,
  output crc64id_pkg::crc_entry_t head,
  output logic                    full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [crc64id_pkg::CRC_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head.valid = (count != '0);
  assign head.crc   = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.crc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && full))
    else $error("CRC pushed into full queue");

endmodule

// ----- rtl/crc64id_back.sv -----
// Back end: expands one finished CRC into ten id characters.
module crc64id_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [crc64id_pkg::OS_CODE_W-1:0]   os_code,
  input  crc64id_pkg::crc_entry_t             head,
  output logic                                pop,
  crc64id_out_if.source                       id_out
);

  logic                                 active;
  logic [crc64id_pkg::CHAR_IDX_W-1:0]   idx;
  logic [crc64id_pkg::CRC_W-1:0]        crc;
  logic [crc64id_pkg::CODE_W-1:0]       codes [crc64id_pkg::ID_CHARS];
  logic                                 load_out;

  logic                          out_valid;
  logic [crc64id_pkg::CHAR_W-1:0] out_char;
  logic                          out_last;
  logic [crc64id_pkg::CRC_W-1:0] out_crc;

  assign id_out.valid     = out_valid;
  assign id_out.id_char   = out_char;
  assign id_out.char_last = out_last;
  assign id_out.crc_value = out_crc;

  // first code mixes the platform code with CRC bit 0, the rest are 6-bit fields
  always_comb begin
    codes[0] = {os_code, crc[0]};
    for (int k = 1; k < crc64id_pkg::ID_CHARS; k++) begin
      codes[k] = crc[1 + (k - 1) * crc64id_pkg::FIELD_STRIDE +: crc64id_pkg::CODE_W];
    end
  end

  assign load_out = active && (!out_valid || id_out.ready);
  assign pop      = !active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        if (idx == crc64id_pkg::LAST_CHAR_IDX) begin
          active <= 1'b0;
          idx    <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (out_valid && id_out.ready) begin
        out_valid <= 1'b0;
      end
      if (!active && head.valid) active <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!active && head.valid) crc <= head.crc;
    if (load_out) begin
      out_char <= crc64id_pkg::code_to_ascii(codes[idx]);
      out_last <= (idx == crc64id_pkg::LAST_CHAR_IDX);
      out_crc  <= crc;
    end
  end

  a_chars_continue: assert property (@(posedge clk) disable iff (rst)
    (out_valid && id_out.ready && !out_last) |=> out_valid)
    else $error("gap inside an identifier");

  a_crc_same_in_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && id_out.ready && !out_last) |=> (out_crc == $past(out_crc)))
    else $error("CRC changed within one identifier");

endmodule

// ----- bench/tb_crc64_device_id_encoder.sv -----
// Testbench for crc64_device_id_encoder: directed and random messages against a CRC-64 id predictor.
module tb_crc64_device_id_encoder;

  localparam int          OS_W           = crc64id_pkg::OS_CODE_W;
  // Reflected ECMA-182 polynomial, zero init, no final xor.
  localparam logic [63:0] ECMA_POLY_REFL = 64'hC96C5795D7870F42;
  localparam int          ID_LEN         = 10;
  localparam int          ID_STRIDE      = 7;
  localparam int          ITEM_TARGET    = 420;
  localparam int          PHASES         = 8;
  localparam int          LONG_HOLD      = 150;
  localparam int          REPORT_LIMIT   = 10;

  // One expected identifier character.
  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic [63:0] crc;
  } id_char_t;

  // Running CRC model plus the queue of characters it has promised.
  class device_id_predictor;
    logic [63:0]     crc_acc;
    logic [OS_W-1:0] os_code;
    id_char_t        expected_chars[$];
    int              mismatches;
    int              chars_checked;
    int              messages;

    function new();
      crc_acc       = '0;
      os_code       = 5'd2;
      mismatches    = 0;
      chars_checked = 0;
      messages      = 0;
    endfunction

    function logic [7:0] id_alphabet(logic [5:0] code);
      if (code < 6'd26)       return 8'("A") + 8'(code);
      else if (code < 6'd52)  return 8'("a") + 8'(code - 6'd26);
      else if (code < 6'd62)  return 8'("0") + 8'(code - 6'd52);
      else if (code == 6'd62) return 8'("x");
      else                    return 8'("X");
    endfunction

    // Notes one accepted msg_in transfer.
    function void absorb_transfer(logic [7:0] data, logic present, logic ends);
      logic [63:0] shifted;
      logic [5:0]  code;
      id_char_t    item;
      if (present) begin
        crc_acc = crc_acc ^ {56'd0, data};
        for (int b = 0; b < 8; b++)
          crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ ECMA_POLY_REFL) : (crc_acc >> 1);
      end
      if (!ends) return;
      for (int k = 0; k < ID_LEN; k++) begin
        if (k == 0) begin
          code = {os_code, crc_acc[0]};
        end else begin
          shifted = crc_acc >> (1 + ID_STRIDE * (k - 1));
          code    = shifted[5:0];
        end
        item.ch   = id_alphabet(code);
        item.last = (k == ID_LEN - 1);
        item.crc  = crc_acc;
        expected_chars.push_back(item);
      end
      crc_acc = '0;
      messages++;
    endfunction

    function void report(string what, id_char_t exp_c, id_char_t act_c);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch (%s): expected char %h last %b crc %h, got char %h last %b crc %h",
                 what, exp_c.ch, exp_c.last, exp_c.crc, act_c.ch, act_c.last, act_c.crc);
    endfunction

    // Checks one accepted id_out transfer against the oldest promise.
    function void check_char(logic [7:0] ch, logic last, logic [63:0] crc);
      id_char_t act_c;
      id_char_t exp_c;
      act_c.ch   = ch;
      act_c.last = last;
      act_c.crc  = crc;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        exp_c.ch   = 'x;
        exp_c.last = 'x;
        exp_c.crc  = 'x;
        report("unexpected", exp_c, act_c);
        return;
      end
      exp_c = expected_chars.pop_front();
      if (exp_c.ch !== ch || exp_c.last !== last || exp_c.crc !== crc)
        report("field", exp_c, act_c);
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            os_code_we;
  logic [OS_W-1:0] os_code_wdata;

  crc64id_in_if  msg_if ();
  crc64id_out_if id_if ();

  crc64_device_id_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .msg_in       (msg_if),
    .id_out       (id_if),
    .os_code_we   (os_code_we),
    .os_code_wdata(os_code_wdata)
  );

  device_id_predictor id_model = new();

  // Knobs shared by the stimulus and the id_out ready process.
  bit in_gaps;
  bit out_gaps;
  int hold_request;
  int items_sent;
  int cfg_writes;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Everything the DUT sees is known from time 0.
  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    os_code_we        = 1'b0;
    os_code_wdata     = '0;
    msg_if.valid      = 1'b0;
    msg_if.data_byte  = '0;
    msg_if.byte_present = 1'b0;
    msg_if.message_end  = 1'b0;
    id_if.ready       = 1'b0;
    in_gaps           = 1'b0;
    out_gaps          = 1'b0;
    hold_request      = 0;
    items_sent        = 0;
    cfg_writes        = 0;
  end

  // Receiver side: random ready bursts, or a long counted hold when asked.
  initial begin : ready_ctl
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        id_if.ready = 1'b0;
      end else if (hold_left > 0) begin
        id_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        id_if.ready = 1'b0;
        stall_left--;
      end else if (out_gaps && $urandom_range(0, 6) == 0) begin
        // start a stall burst of random length, this cycle included
        id_if.ready = 1'b0;
        stall_left  = $urandom_range(0, 18);
      end else begin
        id_if.ready = 1'b1;
      end
    end
  end

  // Every id_out transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && id_if.valid && id_if.ready)
      id_model.check_char(id_if.id_char, id_if.char_last, id_if.crc_value);
  end

  // Offers one msg_in item and holds it until the transfer happens.
  task automatic send_item(logic [7:0] data, logic present, logic ends);
    @(negedge clk);
    msg_if.valid        = 1'b1;
    msg_if.data_byte    = data;
    msg_if.byte_present = present;
    msg_if.message_end  = ends;
    do @(posedge clk); while (!(msg_if.valid && msg_if.ready));
    id_model.absorb_transfer(data, present, ends);
    if (present || ends) items_sent++;
    // optional sender gap of random length, payload scrambled while idle
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 19)) begin
        @(negedge clk);
        msg_if.valid        = 1'b0;
        msg_if.data_byte    = 8'($urandom);
        msg_if.byte_present = 1'($urandom);
        msg_if.message_end  = 1'($urandom);
      end
    end
  endtask

  // Sender pause until every promised character has come out, plus slack.
  task automatic drain();
    @(negedge clk);
    msg_if.valid = 1'b0;
    while (id_model.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_os_code(logic [OS_W-1:0] value);
    drain();
    @(negedge clk);
    os_code_we    = 1'b1;
    os_code_wdata = value;
    @(negedge clk);
    os_code_we    = 1'b0;
    os_code_wdata = OS_W'($urandom);
    id_model.os_code = value;
    cfg_writes++;
  endtask

  // Well-formed message: len bytes, occasional no-op items in between,
  // closed either by a byte carrying the end mark or by a bare end mark.
  task automatic send_message(int len);
    bit end_with_byte;
    end_with_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len - (end_with_byte ? 1 : 0); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    if (end_with_byte) send_item(8'($urandom), 1'b1, 1'b1);
    else               send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int phase_goal;
    int len;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, os_code at its reset value.
    send_item(8'h5A, 1'b0, 1'b1);          // empty message, CRC stays zero
    send_item(8'h00, 1'b1, 1'b1);          // single zero byte with the end mark
    send_item(8'hFF, 1'b1, 1'b1);          // single all-ones byte with the end mark
    send_item(8'hA7, 1'b0, 1'b0);          // no byte, no end: nothing should happen
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);          // bare end mark closes a 3-byte message; data ignored
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h7F, 1'b0, 1'b0);          // ignored byte mid-message
    send_item(8'h3C, 1'b1, 1'b1);          // byte folded in before the id is formed
    write_os_code(5'd31);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h12, 1'b1, 1'b1);
    write_os_code(5'd0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFE, 1'b1, 1'b0);
    send_item(8'hED, 1'b1, 1'b1);

    // Random part in phases; each phase starts idle with a fresh os_code.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_os_code(5'd31);
        1:       write_os_code(5'd0);
        PHASES - 1: write_os_code(OS_W'($urandom));
        default: write_os_code(OS_W'($urandom));
      endcase
      in_gaps  = (p == 0 || p == 2 || p == 4 || p == 5);
      out_gaps = (p == 1 || p == 2 || p == 4 || p == 5);
      phase_goal = 25 + (p + 1) * (ITEM_TARGET - 25) / PHASES;
      if (p == 3) begin
        // Back-pressure: id_out held off while short messages keep coming,
        // so the CRC queue fills and msg_in.ready must drop.
        hold_request = LONG_HOLD;
        while (items_sent < phase_goal) send_message($urandom_range(0, 2));
      end else begin
        while (items_sent < phase_goal) begin
          if ($urandom_range(0, 6) == 0) begin
            // broken or noisy traffic: any mix of byte and end mark
            send_item(8'($urandom), 1'($urandom), 1'($urandom));
          end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
            send_message(len);
          end
        end
      end
    end

    // Wind down: let everything come out, then a little slack.
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    @(negedge clk);
    msg_if.valid = 1'b0;
    while (id_model.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d messages from %0d byte/end transfers, %0d id chars checked",
             id_model.messages, items_sent, id_model.chars_checked);
    $display("%0d os_code writes incl. both extremes, one %0d-cycle output hold, %0d mismatches",
             cfg_writes, LONG_HOLD, id_model.mismatches);
    if (id_model.mismatches == 0 && id_model.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
